// File: rtl/ftra_pkg.sv
// Package for the first-fit tile run allocator.
// Holds field widths, default sizes, codes, transfer structs and sequencer types.
// Depends on nothing; every other file of the block but ftra_ram refers to it by scoped names.
package ftra_pkg;

	localparam int TILE_SLOTS_DEF = 1024;
	localparam int CORE_COUNT_DEF = 2;

	localparam int START_W = 10;
	localparam int LEN_W   = 11;
	localparam int INDEX_W = 10;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic               op;
		logic               core_sel;
		logic [START_W-1:0] start_tile;
		logic [LEN_W-1:0]   run_length;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [INDEX_W-1:0] tile_index;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_FREE,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic accept;
		logic immediate;
		logic is_alloc;
		logic clear_last;
		logic found;
		logic scan_fail;
		logic wr_last;
		logic out_free;
	} stat_t;

	typedef struct packed {
		logic idle;
		logic clr_we;
		logic scan_en;
		logic wr_en;
		logic load_rsp;
	} ctrl_t;

endpackage

// File: rtl/ftra_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Width and depth are parameters; no package dependency.
module ftra_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/ftra_fsm.sv
// Sequencer of the tile run allocator: clear pass, scan, mark, free and response.
// Uses the state, status and control types of ftra_pkg.
module ftra_fsm (
	input  logic           clk,
	input  logic           arst_n,
	input  ftra_pkg::stat_t stat,
	output ftra_pkg::ctrl_t ctrl
);

	ftra_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ftra_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ftra_pkg::ST_CLEAR: begin
				if (stat.clear_last) state_d = ftra_pkg::ST_IDLE;
			end
			ftra_pkg::ST_IDLE: begin
				if (stat.accept) begin
					if (stat.immediate) state_d = ftra_pkg::ST_RESP;
					else if (stat.is_alloc) state_d = ftra_pkg::ST_SCAN;
					else state_d = ftra_pkg::ST_FREE;
				end
			end
			ftra_pkg::ST_SCAN: begin
				if (stat.found) state_d = ftra_pkg::ST_MARK;
				else if (stat.scan_fail) state_d = ftra_pkg::ST_RESP;
			end
			ftra_pkg::ST_MARK, ftra_pkg::ST_FREE: begin
				if (stat.wr_last) state_d = ftra_pkg::ST_RESP;
			end
			ftra_pkg::ST_RESP: begin
				if (stat.out_free) state_d = ftra_pkg::ST_IDLE;
			end
			default: state_d = ftra_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			ftra_pkg::ST_CLEAR: ctrl.clr_we = 1'b1;
			ftra_pkg::ST_IDLE:  ctrl.idle = 1'b1;
			ftra_pkg::ST_SCAN:  ctrl.scan_en = 1'b1;
			ftra_pkg::ST_MARK, ftra_pkg::ST_FREE: ctrl.wr_en = 1'b1;
			ftra_pkg::ST_RESP:  ctrl.load_rsp = stat.out_free;
			default: ctrl = '0;
		endcase
	end

endmodule

// File: rtl/first_fit_tile_run_allocator.sv
// Top level of the first-fit tile run allocator.
// Instantiates ftra_fsm and ftra_ram and holds the scan and write datapath.
// Depends on ftra_pkg for field widths, codes and transfer structs.
//
// Requests arrive on req/req_valid/req_stall; one result per request leaves on
// rsp/rsp_valid/rsp_stall. A transfer happens when valid is high and stall low.
// The used-bit map of all cores lives in one single-bit RAM, one slot per word.
// After reset the block runs a clearing pass over all CORE_COUNT * TILE_SLOTS
// map words (2048 at the defaults) that marks slot 0 of each core reserved;
// req_stall stays high during it.
// One request is worked on at a time. An allocate scans the map one slot per
// cycle through the RAM read port, then marks a run it finds through the
// single RAM write port. A free clears its run slot by slot through that write
// port. Rejected requests go straight to the response without touching the map.
// The result goes to an output register; a new request is taken while it waits.
// If the receiver stalls, a finished result is held inside until it has room.
module first_fit_tile_run_allocator #(
	parameter int TILE_SLOTS = ftra_pkg::TILE_SLOTS_DEF,
	parameter int CORE_COUNT = ftra_pkg::CORE_COUNT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ftra_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ftra_pkg::rsp_t rsp
);

	localparam int DEPTH = CORE_COUNT * TILE_SLOTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = $clog2(TILE_SLOTS);
	localparam int SW1   = $clog2(TILE_SLOTS + 1);
	localparam int FW    = (SW1 > ftra_pkg::LEN_W + 1) ? SW1 : ftra_pkg::LEN_W + 1;

	function automatic logic [AW-1:0] slot_addr(input logic core, input logic [SW-1:0] slot);
		return AW'(slot) + (core ? AW'(TILE_SLOTS) : AW'(0));
	endfunction

	ftra_pkg::stat_t stat;
	ftra_pkg::ctrl_t ctrl;

	logic [AW-1:0]  clr_addr_q;
	logic [SW-1:0]  clr_slot_q;
	logic [SW1-1:0] rd_slot_q;
	logic [SW-1:0]  chk_slot_s1;
	logic           chk_vld_s1;
	logic [SW1-1:0] run_q;
	logic [SW1-1:0] len_q;
	logic           core_q;
	logic [FW-1:0]  wr_slot_q;
	logic [FW-1:0]  stop_q;
	logic [0:0]     wr_bit_q;
	logic           res_ok_q;
	logic [ftra_pkg::INDEX_W-1:0] res_idx_q;
	logic           rsp_valid_q;
	ftra_pkg::rsp_t rsp_q;

	logic           accept;
	logic           missing;
	logic           imm_alloc;
	logic           imm_free;
	logic           issue;
	logic [0:0]     rd_data;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [0:0]     ram_wdata;
	logic [FW-1:0]  free_sum;
	logic [FW-1:0]  free_stop;
	logic [FW-1:0]  found_start;

	assign accept    = req_valid && !req_stall;
	assign req_stall = !ctrl.idle;
	assign missing   = 32'(req.core_sel) >= CORE_COUNT;
	assign imm_alloc = missing || (req.run_length == '0) || (32'(req.run_length) > TILE_SLOTS);
	assign imm_free  = missing || (req.run_length == '0) || (32'(req.start_tile) >= TILE_SLOTS);
	assign issue     = ctrl.scan_en && (rd_slot_q != SW1'(TILE_SLOTS));

	assign free_sum    = FW'(req.start_tile) + FW'(req.run_length);
	assign free_stop   = (free_sum > FW'(TILE_SLOTS)) ? FW'(TILE_SLOTS) : free_sum;
	assign found_start = FW'(chk_slot_s1) + FW'(1) - FW'(len_q);

	always_comb begin
		stat            = '0;
		stat.accept     = accept;
		stat.immediate  = (req.op == ftra_pkg::OP_ALLOC) ? imm_alloc : imm_free;
		stat.is_alloc   = (req.op == ftra_pkg::OP_ALLOC);
		stat.clear_last = (clr_addr_q == AW'(DEPTH - 1));
		stat.found      = ctrl.scan_en && chk_vld_s1 && !rd_data[0] && (run_q + 1'b1 == len_q);
		stat.scan_fail  = ctrl.scan_en && chk_vld_s1 && (chk_slot_s1 == SW'(TILE_SLOTS - 1));
		stat.wr_last    = (wr_slot_q + 1'b1 == stop_q);
		stat.out_free   = !rsp_valid_q || !rsp_stall;
	end

	ftra_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	assign ram_we    = ctrl.clr_we || ctrl.wr_en;
	assign ram_waddr = ctrl.clr_we ? clr_addr_q : slot_addr(core_q, wr_slot_q[SW-1:0]);
	assign ram_wdata = ctrl.clr_we ? 1'(clr_slot_q == '0) : wr_bit_q;

	ftra_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (slot_addr(core_q, rd_slot_q[SW-1:0])),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			clr_slot_q  <= '0;
			chk_vld_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctrl.clr_we) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				clr_slot_q <= (clr_slot_q == SW'(TILE_SLOTS - 1)) ? '0 : clr_slot_q + 1'b1;
			end
			chk_vld_s1 <= issue;
			if (ctrl.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			core_q    <= req.core_sel;
			len_q     <= SW1'(req.run_length);
			rd_slot_q <= '0;
			run_q     <= '0;
			wr_slot_q <= FW'(req.start_tile);
			stop_q    <= free_stop;
			wr_bit_q  <= 1'b0;
			res_ok_q  <= (req.op == ftra_pkg::OP_FREE);
			res_idx_q <= '0;
		end
		if (issue) begin
			rd_slot_q   <= rd_slot_q + 1'b1;
			chk_slot_s1 <= rd_slot_q[SW-1:0];
		end
		if (ctrl.scan_en && chk_vld_s1) begin
			run_q <= rd_data[0] ? '0 : run_q + 1'b1;
		end
		if (stat.found) begin
			wr_slot_q <= found_start;
			stop_q    <= FW'(chk_slot_s1) + FW'(1);
			wr_bit_q  <= 1'b1;
			res_ok_q  <= 1'b1;
			res_idx_q <= found_start[ftra_pkg::INDEX_W-1:0];
		end
		if (ctrl.wr_en) begin
			wr_slot_q <= wr_slot_q + 1'b1;
		end
		if (ctrl.load_rsp) begin
			rsp_q.ok         <= res_ok_q;
			rsp_q.tile_index <= res_idx_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: tb/tb_first_fit_tile_run_allocator.sv
`timescale 1ns / 1ps
// Testbench for first_fit_tile_run_allocator: directed, back-pressure and random tests.
// Predicts every result from its own copy of the per-core tile maps; depends on ftra_pkg.
module tb_first_fit_tile_run_allocator;

	localparam int SLOTS = ftra_pkg::TILE_SLOTS_DEF;
	localparam int CORES = ftra_pkg::CORE_COUNT_DEF;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 550;
	localparam int QUIET_ITEMS = 60;

	typedef struct {
		logic core;
		int   first;
		int   len;
	} tile_run_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	ftra_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	ftra_pkg::rsp_t rsp;

	logic           tile_used [CORES][SLOTS];
	ftra_pkg::rsp_t expected_rsp [$];
	tile_run_t      live_runs [$];
	int             fail_cnt = 0;
	int             idle_cycles = 0;
	bit             quiet = 1'b0;
	bit             hold_rsp = 1'b0;

	first_fit_tile_run_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic ftra_pkg::rsp_t predict_tile_run(ftra_pkg::req_t r);
		ftra_pkg::rsp_t res;
		int   run;
		int   first;
		int   len;
		res = '0;
		len = int'(r.run_length);
		if (r.op == ftra_pkg::OP_FREE) begin
			res.ok = 1'b1;
			if (int'(r.core_sel) < CORES) begin
				for (int k = 0; k < len; k++) begin
					if (int'(r.start_tile) + k >= SLOTS)
						break;
					tile_used[r.core_sel][int'(r.start_tile) + k] = 1'b0;
				end
			end
			return res;
		end
		if (int'(r.core_sel) >= CORES || len == 0 || len > SLOTS)
			return res;
		run = 0;
		for (int i = 0; i < SLOTS; i++) begin
			if (tile_used[r.core_sel][i]) begin
				run = 0;
			end else begin
				run++;
				if (run == len) begin
					first = i + 1 - len;
					for (int k = first; k <= i; k++)
						tile_used[r.core_sel][k] = 1'b1;
					res.ok = 1'b1;
					res.tile_index = ftra_pkg::INDEX_W'(first);
					return res;
				end
			end
		end
		return res;
	endfunction

	task automatic send_tile_req(input logic op, input logic core, input int first, input int len);
		ftra_pkg::req_t r;
		ftra_pkg::rsp_t res;
		int   gap;
		r.op = op;
		r.core_sel = core;
		r.start_tile = ftra_pkg::START_W'(first);
		r.run_length = ftra_pkg::LEN_W'(len);
		gap = 0;
		if (!quiet && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		res = predict_tile_run(r);
		expected_rsp.push_back(res);
		if (op == ftra_pkg::OP_ALLOC && res.ok)
			live_runs.push_back('{core, int'(res.tile_index), len});
	endtask

	// Each accepted result is compared with the oldest outstanding prediction.
	always @(posedge clk) begin
		ftra_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				$error("unexpected result: ok %0b tile_index %0d", rsp.ok, rsp.tile_index);
				fail_cnt++;
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.ok !== want.ok) begin
					$error("ok: expected %0b, got %0b", want.ok, rsp.ok);
					fail_cnt++;
				end
				if (rsp.tile_index !== want.tile_index) begin
					$error("tile_index: expected %0d, got %0d", want.tile_index,
						rsp.tile_index);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		@(posedge clk);
		forever begin
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end else if (quiet || $urandom_range(0, 2) != 0) begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	task automatic test_edge_cases();
		send_tile_req(ftra_pkg::OP_ALLOC, 1'b0, 0, 0);
		send_tile_req(ftra_pkg::OP_ALLOC, 1'b0, 1023, 1);
		send_tile_req(ftra_pkg::OP_ALLOC, 1'b0, 0, 1024);
		send_tile_req(ftra_pkg::OP_ALLOC, 1'b0, 512, 2047);
		send_tile_req(ftra_pkg::OP_ALLOC, 1'b0, 0, 1025);
		// A run that ends exactly at the last slot must be found.
		send_tile_req(ftra_pkg::OP_ALLOC, 1'b1, 0, 1023);
		send_tile_req(ftra_pkg::OP_ALLOC, 1'b1, 0, 1);
		send_tile_req(ftra_pkg::OP_FREE, 1'b1, 1023, 2047);
		send_tile_req(ftra_pkg::OP_ALLOC, 1'b1, 0, 1);
		send_tile_req(ftra_pkg::OP_FREE, 1'b1, 0, 1024);
		send_tile_req(ftra_pkg::OP_ALLOC, 1'b1, 341, 1024);
		send_tile_req(ftra_pkg::OP_FREE, 1'b1, 512, 0);
		send_tile_req(ftra_pkg::OP_ALLOC, 1'b1, 0, 1);
		send_tile_req(ftra_pkg::OP_FREE, 1'b1, 0, 1024);
		send_tile_req(ftra_pkg::OP_FREE, 1'b0, 0, 1);
		send_tile_req(ftra_pkg::OP_ALLOC, 1'b0, 682, 1);
		send_tile_req(ftra_pkg::OP_ALLOC, 1'b0, 0, 3);
		send_tile_req(ftra_pkg::OP_FREE, 1'b0, 0, 1024);
	endtask

	task automatic test_backpressure();
		hold_rsp = 1'b1;
		for (int n = 0; n < 10; n++)
			send_tile_req(ftra_pkg::OP_ALLOC, 1'($urandom_range(0, 1)),
				$urandom_range(0, 1023), $urandom_range(1, 4));
	endtask

	task automatic test_random_traffic(input int count);
		tile_run_t rr;
		int        pick;
		int        idx;
		for (int n = 0; n < count; n++) begin
			if (n == count - QUIET_ITEMS)
				quiet = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_tile_req(ftra_pkg::OP_ALLOC, 1'($urandom_range(0, 1)),
					$urandom_range(0, 1023), $urandom_range(1, 16));
			end else if (pick < 75 && live_runs.size() > 0) begin
				idx = $urandom_range(0, live_runs.size() - 1);
				rr = live_runs[idx];
				live_runs.delete(idx);
				send_tile_req(ftra_pkg::OP_FREE, rr.core, rr.first, rr.len);
			end else if (pick < 85) begin
				send_tile_req(ftra_pkg::OP_FREE, 1'($urandom_range(0, 1)),
					$urandom_range(0, 1023),
					$urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, 2047));
			end else if (pick < 93) begin
				send_tile_req(ftra_pkg::OP_ALLOC, 1'($urandom_range(0, 1)),
					$urandom_range(0, 1023), $urandom_range(17, 300));
			end else begin
				send_tile_req(ftra_pkg::OP_ALLOC, 1'($urandom_range(0, 1)),
					$urandom_range(0, 1023), $urandom_range(0, 2047));
			end
		end
	endtask

	initial begin
		for (int c = 0; c < CORES; c++)
			for (int i = 0; i < SLOTS; i++)
				tile_used[c][i] = (i == 0);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_edge_cases();
		test_backpressure();
		test_random_traffic(RANDOM_ITEMS);
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/ftra_pkg.sv
rtl/ftra_ram.sv
rtl/ftra_fsm.sv
rtl/first_fit_tile_run_allocator.sv
tb/tb_first_fit_tile_run_allocator.sv
